FILE: src/cmt_pkg.sv
// ----------------------------------------------------------------------------
// cmt_pkg
// Shared types and constants of the four-channel compare match timer.
// ----------------------------------------------------------------------------
package cmt_pkg;

    localparam int DATA_WIDTH  = 16;
    localparam int PRESC_WIDTH = 9;
    localparam int IE_BIT      = 6;
    localparam int MASK_WIDTH  = 4;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        SEL_CONTROL = 2'd0,
        SEL_COMPARE = 2'd1,
        SEL_COUNTER = 2'd2,
        SEL_START   = 2'd3
    } t_reg_sel;

    localparam logic [DATA_WIDTH-1:0] COMPARE_RESET = 16'hFFFF;

    // Per-channel strobe group driven by the top level
    typedef struct packed {
        logic                  tick;
        logic                  wr;
        t_reg_sel              sel;
        logic [DATA_WIDTH-1:0] wdata;
    } t_chan_ctl;

    // Last prescaler count of a prescaled tick: divisor minus one
    function automatic logic [PRESC_WIDTH-1:0] presc_limit(input logic [1:0] cs);
        logic [PRESC_WIDTH-1:0] lim;
        case (cs)
            2'd0:    lim = 9'd7;
            2'd1:    lim = 9'd31;
            2'd2:    lim = 9'd127;
            default: lim = 9'd511;
        endcase
        return lim;
    endfunction

endpackage

FILE: src/cmt_channel.sv
// ----------------------------------------------------------------------------
// cmt_channel
// One timer channel: registers, prescaler and compare match counter.
// ----------------------------------------------------------------------------
module cmt_channel #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  cmt_pkg::t_chan_ctl              i_ctl,
    output logic [cmt_pkg::DATA_WIDTH-1:0]  o_rd_data,
    output logic                            o_match,
    output logic                            o_ie
);
    import cmt_pkg::*;

    logic [COUNT_WIDTH-1:0] r_counter,  n_counter;
    logic [COUNT_WIDTH-1:0] r_compare,  n_compare;
    logic [1:0]             r_cs,       n_cs;
    logic                   r_ie,       n_ie;
    logic                   r_run,      n_run;
    logic [PRESC_WIDTH-1:0] r_presc,    n_presc;

    logic [COUNT_WIDTH+DATA_WIDTH-1:0] wdata_ext;
    logic [COUNT_WIDTH+DATA_WIDTH-1:0] counter_ext;
    logic [COUNT_WIDTH+DATA_WIDTH-1:0] compare_ext;
    logic [COUNT_WIDTH+DATA_WIDTH-1:0] compare_rst_ext;
    logic [COUNT_WIDTH-1:0]            wdata_cw;
    logic                              presc_done;
    logic                              hit;

    assign wdata_ext       = {{COUNT_WIDTH{1'b0}}, i_ctl.wdata};
    assign wdata_cw        = wdata_ext[COUNT_WIDTH-1:0];
    assign counter_ext     = {{DATA_WIDTH{1'b0}}, r_counter};
    assign compare_ext     = {{DATA_WIDTH{1'b0}}, r_compare};
    assign compare_rst_ext = {{COUNT_WIDTH{1'b0}}, COMPARE_RESET};

    assign presc_done = (r_presc >= presc_limit(r_cs));
    assign hit        = (r_counter == r_compare);

    always_comb begin
        n_counter = r_counter;
        n_compare = r_compare;
        n_cs      = r_cs;
        n_ie      = r_ie;
        n_run     = r_run;
        n_presc   = r_presc;
        o_match   = 1'b0;
        if (i_ctl.tick && r_run) begin
            if (!presc_done) begin
                n_presc = r_presc + 1'b1;
            end else begin
                n_presc = '0;
                if (hit) begin
                    n_counter = '0;
                    o_match   = 1'b1;
                end else begin
                    n_counter = r_counter + 1'b1;
                end
            end
        end
        if (i_ctl.wr) begin
            case (i_ctl.sel)
                SEL_CONTROL: begin
                    n_cs = i_ctl.wdata[1:0];
                    n_ie = i_ctl.wdata[IE_BIT];
                end
                SEL_COMPARE: n_compare = wdata_cw;
                SEL_COUNTER: n_counter = wdata_cw;
                SEL_START:   n_run     = i_ctl.wdata[0];
                default:     n_run     = r_run;
            endcase
        end
    end

    always_comb begin
        case (i_ctl.sel)
            SEL_CONTROL: begin
                o_rd_data         = '0;
                o_rd_data[1:0]    = r_cs;
                o_rd_data[IE_BIT] = r_ie;
            end
            SEL_COMPARE: o_rd_data = compare_ext[DATA_WIDTH-1:0];
            SEL_COUNTER: o_rd_data = counter_ext[DATA_WIDTH-1:0];
            SEL_START:   o_rd_data = {{(DATA_WIDTH-1){1'b0}}, r_run};
            default:     o_rd_data = '0;
        endcase
    end

    assign o_ie = r_ie;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= '0;
            r_compare <= compare_rst_ext[COUNT_WIDTH-1:0];
            r_cs      <= '0;
            r_ie      <= 1'b0;
            r_run     <= 1'b0;
            r_presc   <= '0;
        end else begin
            r_counter <= n_counter;
            r_compare <= n_compare;
            r_cs      <= n_cs;
            r_ie      <= n_ie;
            r_run     <= n_run;
            r_presc   <= n_presc;
        end
    end

endmodule

FILE: src/compare_match_timer_4ch.sv
// ----------------------------------------------------------------------------
// compare_match_timer_4ch
// Multi-channel 16-bit compare match timer with per-channel prescaler.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries one item per handshake:
// a peripheral-clock tick, a register write or a register read, addressed by
// i_channel and i_reg_sel. Output channel (o_out_valid / i_out_ready) returns
// exactly one item per input item: read data, match mask and interrupt mask.
// An accepted item lands in the input register; when it advances, it updates the channel
// state and its result is written to the result register on the same edge.
// Throughput is one item per cycle while the receiver does not stall; the only
// serial path is the channel state update.
// While the receiver stalls, the result register holds and the input register
// keeps at most one more item; o_in_ready drops only when both are full.
// Reset (synchronous, active low) stops all channels, clears counters,
// prescalers and control, sets compare values to 0xFFFF and empties both
// registers.
// ----------------------------------------------------------------------------
module compare_match_timer_4ch #(
    parameter int NUM_CHANNELS = 4,
    parameter int COUNT_WIDTH  = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_cmd,
    input  logic [1:0]                        i_channel,
    input  logic [1:0]                        i_reg_sel,
    input  logic [cmt_pkg::DATA_WIDTH-1:0]    i_write_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [cmt_pkg::DATA_WIDTH-1:0]    o_read_data,
    output logic [cmt_pkg::MASK_WIDTH-1:0]    o_match_mask,
    output logic [cmt_pkg::MASK_WIDTH-1:0]    o_irq_mask
);
    import cmt_pkg::*;

    logic                  r_in_valid;
    logic [1:0]            r_cmd;
    logic [1:0]            r_channel;
    logic [1:0]            r_reg_sel;
    logic [DATA_WIDTH-1:0] r_write_data;

    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_read_data, n_read_data;
    logic [MASK_WIDTH-1:0] r_match,     n_match;
    logic [MASK_WIDTH-1:0] r_irq,       n_irq;

    logic advance;
    logic is_tick, is_write, is_read;

    t_chan_ctl                           ch_ctl   [NUM_CHANNELS];
    logic [DATA_WIDTH-1:0]               ch_rd    [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]             ch_match;
    logic [NUM_CHANNELS-1:0]             ch_ie;
    logic [NUM_CHANNELS+MASK_WIDTH-1:0]  match_pad;
    logic [NUM_CHANNELS+MASK_WIDTH-1:0]  irq_pad;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_comb begin
        is_tick  = 1'b0;
        is_write = 1'b0;
        is_read  = 1'b0;
        case (t_cmd'(r_cmd))
            CMD_TICK:  is_tick  = 1'b1;
            CMD_WRITE: is_write = 1'b1;
            CMD_READ:  is_read  = 1'b1;
            default:   is_tick  = 1'b0;
        endcase
    end

    for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
        assign ch_ctl[c].tick  = advance && is_tick;
        assign ch_ctl[c].wr    = advance && is_write && (int'(r_channel) == c);
        assign ch_ctl[c].sel   = t_reg_sel'(r_reg_sel);
        assign ch_ctl[c].wdata = r_write_data;

        cmt_channel #(
            .COUNT_WIDTH(COUNT_WIDTH)
        ) u_channel (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (ch_ctl[c]),
            .o_rd_data (ch_rd[c]),
            .o_match   (ch_match[c]),
            .o_ie      (ch_ie[c])
        );
    end

    // Channels past the mask width count but report no match bit
    assign match_pad = {{MASK_WIDTH{1'b0}}, ch_match};
    assign irq_pad   = {{MASK_WIDTH{1'b0}}, ch_match & ch_ie};

    always_comb begin
        n_read_data = '0;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (is_read && int'(r_channel) == c) begin
                n_read_data = n_read_data | ch_rd[c];
            end
        end
        n_match = match_pad[MASK_WIDTH-1:0];
        n_irq   = irq_pad[MASK_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: load on accept, hold while stalled
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd        <= i_cmd;
            r_channel    <= i_channel;
            r_reg_sel    <= i_reg_sel;
            r_write_data <= i_write_data;
        end
        if (advance) begin
            r_read_data <= n_read_data;
            r_match     <= n_match;
            r_irq       <= n_irq;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_data  = r_read_data;
    assign o_match_mask = r_match;
    assign o_irq_mask   = r_irq;

endmodule

FILE: test/compare_match_timer_4ch_tb.sv
// ----------------------------------------------------------------------------
// compare_match_timer_4ch_tb
// Self-checking bench for the four-channel compare match timer. A driver
// feeds ticks, register writes and register reads from a queue, a predictor
// keeps its own copy of every channel and works out the read data and the
// match and interrupt masks, and a monitor compares each returned item in
// order. Both sides idle at random, and one long output stall backs the
// block up until it refuses input.
// ----------------------------------------------------------------------------
module compare_match_timer_4ch_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cmt_pkg::*;

    localparam int         NUM_CH     = 4;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         QUIET_MAX  = 2000;
    localparam int         PRINT_MAX  = 100;

    typedef struct packed {
        logic [1:0]            cmd;
        logic [1:0]            chan;
        logic [1:0]            sel;
        logic [DATA_WIDTH-1:0] wdata;
    } timer_op_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] rdata;
        logic [MASK_WIDTH-1:0] match;
        logic [MASK_WIDTH-1:0] irq;
    } timer_resp_t;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_in_valid   = 1'b0;
    logic [1:0]            i_cmd        = '0;
    logic [1:0]            i_channel    = '0;
    logic [1:0]            i_reg_sel    = '0;
    logic [DATA_WIDTH-1:0] i_write_data = '0;
    logic                  i_out_ready  = 1'b0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [DATA_WIDTH-1:0] o_read_data;
    logic [MASK_WIDTH-1:0] o_match_mask;
    logic [MASK_WIDTH-1:0] o_irq_mask;

    timer_op_t   timer_ops[$];
    timer_resp_t predicted_results[$];

    // Predicted channel state
    logic [DATA_WIDTH-1:0]  cnt_q   [NUM_CH];
    logic [DATA_WIDTH-1:0]  cmp_q   [NUM_CH];
    logic [1:0]             csel_q  [NUM_CH];
    logic                   ie_q    [NUM_CH];
    logic                   run_q   [NUM_CH];
    logic [PRESC_WIDTH-1:0] presc_q [NUM_CH];

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int stall_left     = 0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;

    compare_match_timer_4ch dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_channel    (i_channel),
        .i_reg_sel    (i_reg_sel),
        .i_write_data (i_write_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_read_data  (o_read_data),
        .o_match_mask (o_match_mask),
        .o_irq_mask   (o_irq_mask)
    );

    always #10 i_clk = ~i_clk;

    // Advance the predicted timer by one item and return its result
    function automatic timer_resp_t predict_timer(input timer_op_t op);
        timer_resp_t r;
        int          lim;
        r = '0;
        case (op.cmd)
            CMD_TICK: begin
                for (int c = 0; c < NUM_CH; c++) begin
                    if (run_q[c]) begin
                        lim = (8 << (2 * csel_q[c])) - 1;
                        // a shrunken divisor completes on the current tick
                        if (presc_q[c] < lim) begin
                            presc_q[c] = presc_q[c] + 1'b1;
                        end else begin
                            presc_q[c] = '0;
                            if (cnt_q[c] == cmp_q[c]) begin
                                cnt_q[c]   = '0;
                                r.match[c] = 1'b1;
                                r.irq[c]   = ie_q[c];
                            end else begin
                                cnt_q[c] = cnt_q[c] + 1'b1;
                            end
                        end
                    end
                end
            end
            CMD_WRITE: begin
                case (op.sel)
                    SEL_CONTROL: begin
                        csel_q[op.chan] = op.wdata[1:0];
                        ie_q[op.chan]   = op.wdata[IE_BIT];
                    end
                    SEL_COMPARE: cmp_q[op.chan] = op.wdata;
                    SEL_COUNTER: cnt_q[op.chan] = op.wdata;
                    default:     run_q[op.chan] = op.wdata[0];
                endcase
            end
            CMD_READ: begin
                case (op.sel)
                    SEL_CONTROL: begin
                        r.rdata[1:0]    = csel_q[op.chan];
                        r.rdata[IE_BIT] = ie_q[op.chan];
                    end
                    SEL_COMPARE: r.rdata = cmp_q[op.chan];
                    SEL_COUNTER: r.rdata = cnt_q[op.chan];
                    default:     r.rdata[0] = run_q[op.chan];
                endcase
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_WIDTH-1:0] got,
                                   input logic [DATA_WIDTH-1:0] want);
        // keep the log short on a badly broken block
        if (mismatch_count < PRINT_MAX)
            $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic add_op(input logic [1:0] cmd, input logic [1:0] chan,
                          input logic [1:0] sel, input logic [DATA_WIDTH-1:0] wdata);
        timer_ops.push_back('{cmd: cmd, chan: chan, sel: sel, wdata: wdata});
    endtask

    // Mostly ticks, with small compare and counter values so channels match often
    task automatic queue_random(input int n);
        timer_op_t op;
        int        roll;
        for (int i = 0; i < n; i++) begin
            roll     = $urandom_range(0, 99);
            op.chan  = 2'($urandom_range(0, 3));
            op.sel   = 2'($urandom_range(0, 3));
            op.wdata = DATA_WIDTH'($urandom_range(0, 65535));
            if (roll < 68) begin
                op.cmd = CMD_TICK;
            end else if (roll < 88) begin
                op.cmd = CMD_WRITE;
                case (op.sel)
                    SEL_CONTROL: if ($urandom_range(0, 3) != 0) op.wdata[1] = 1'b0;
                    SEL_START:   if ($urandom_range(0, 4) != 0) op.wdata[0] = 1'b1;
                    default: begin
                        if ($urandom_range(0, 3) != 0)
                            op.wdata = DATA_WIDTH'($urandom_range(0, 12));
                    end
                endcase
            end else if (roll < 98) begin
                op.cmd = CMD_READ;
            end else begin
                op.cmd = CMD_UNUSED;
            end
            timer_ops.push_back(op);
        end
    endtask

    task automatic wait_drained();
        while (timer_ops.size() != 0 || predicted_results.size() != 0)
            @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    // Driver: hold each item until taken, then predict it
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                predicted_results.push_back(predict_timer(timer_ops.pop_front()));
            if (!i_in_valid || o_in_ready) begin
                if (timer_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_in_valid   <= 1'b1;
                    i_cmd        <= timer_ops[0].cmd;
                    i_channel    <= timer_ops[0].chan;
                    i_reg_sel    <= timer_ops[0].sel;
                    i_write_data <= timer_ops[0].wdata;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each returned item against the oldest prediction
    always @(posedge i_clk) begin
        timer_resp_t want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (predicted_results.size() == 0) begin
                    report_mismatch("unexpected item, read_data", o_read_data, 'x);
                end else begin
                    want = predicted_results.pop_front();
                    if (o_read_data !== want.rdata)
                        report_mismatch("read_data", o_read_data, want.rdata);
                    if (o_match_mask !== want.match)
                        report_mismatch("match_mask", DATA_WIDTH'(o_match_mask),
                                        DATA_WIDTH'(want.match));
                    if (o_irq_mask !== want.irq)
                        report_mismatch("irq_mask", DATA_WIDTH'(o_irq_mask),
                                        DATA_WIDTH'(want.irq));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: count cycles with work pending and nothing moving
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (timer_ops.size() == 0 && predicted_results.size() == 0))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_MAX) begin
                $display("%0t ns: timeout, no progress for %0d cycles", $time, QUIET_MAX);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        for (int c = 0; c < NUM_CH; c++) begin
            cnt_q[c]   = '0;
            cmp_q[c]   = COMPARE_RESET;
            csel_q[c]  = '0;
            ie_q[c]    = 1'b0;
            run_q[c]   = 1'b0;
            presc_q[c] = '0;
        end

        send_idle_pct = 32;
        recv_idle_pct = 62;

        // unused command with every field bit set
        add_op(CMD_UNUSED, 2'd3, SEL_START, 16'hFFFF);
        // reset values of channel 0
        add_op(CMD_READ, 2'd0, SEL_CONTROL, 16'hA5A5);
        add_op(CMD_READ, 2'd0, SEL_COMPARE, 16'h5A5A);
        add_op(CMD_READ, 2'd0, SEL_COUNTER, 16'h0000);
        add_op(CMD_READ, 2'd0, SEL_START,   16'hFFFF);
        // channel 2 starts above compare and must wrap without a match
        add_op(CMD_WRITE, 2'd2, SEL_COMPARE, 16'h0000);
        add_op(CMD_WRITE, 2'd2, SEL_COUNTER, 16'hFFFF);
        add_op(CMD_WRITE, 2'd2, SEL_CONTROL, 16'h0040);
        add_op(CMD_WRITE, 2'd2, SEL_START,   16'h0001);
        // channel 3 runs at divide by 32, then drops to divide by 8 mid-count
        add_op(CMD_WRITE, 2'd3, SEL_CONTROL, 16'h0001);
        add_op(CMD_WRITE, 2'd3, SEL_COMPARE, 16'h0000);
        add_op(CMD_WRITE, 2'd3, SEL_START,   16'hFFFF);
        repeat (8) add_op(CMD_TICK, 2'd1, SEL_COUNTER, 16'h0000);
        add_op(CMD_WRITE, 2'd3, SEL_CONTROL, 16'hFFBC);
        add_op(CMD_TICK,  2'd0, SEL_CONTROL, 16'h0000);
        add_op(CMD_READ,  2'd2, SEL_COUNTER, 16'h0000);
        add_op(CMD_READ,  2'd3, SEL_CONTROL, 16'h0000);
        add_op(CMD_READ,  2'd3, SEL_START,   16'h0000);

        queue_random(560);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_drained();

        send_idle_pct = 62;
        recv_idle_pct = 32;
        queue_random(580);
        wait_drained();

        // no idling, but one long output stall to back the block up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_left    = 40;
        queue_random(590);
        wait_drained();

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
